// ===== sv/u8u16_pkg.sv =====
package u8u16_pkg;

    // Result queue geometry
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Code point and unit constants
    localparam logic [15:0] REPLACEMENT  = 16'hFFFD;
    localparam logic [15:0] HIGH_SURR    = 16'hD800;
    localparam logic [15:0] LOW_SURR     = 16'hDC00;
    localparam int unsigned PARTIAL_W    = 21;
    localparam int unsigned TRAILS_W     = 3;

    // Up to two code units produced by one input beat
    typedef struct packed {
        logic [1:0]  cnt;
        logic [15:0] unit0;
        logic        sub0;
        logic [15:0] unit1;
        logic        sub1;
    } u8u16_res_t;

endpackage

// ===== sv/u8u16_decode.sv =====
module u8u16_decode
    import u8u16_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       in_byte,
    input  logic             in_final,
    input  logic             room,
    output u8u16_res_t       res
);

    logic                   in_valid_reg, in_valid_next;
    logic [7:0]             in_byte_reg;
    logic                   in_final_reg;
    logic [PARTIAL_W-1:0]   partial_reg, partial_next;
    logic [TRAILS_W-1:0]    trails_reg, trails_next;
    logic [TRAILS_W-1:0]    total_reg, total_next;

    logic                   adv;
    logic                   load;
    logic                   is_cont;
    logic                   is_ascii;
    logic                   lead_ok;
    logic [TRAILS_W-1:0]    lead_trails;
    logic [4:0]             lead_bits;
    logic [PARTIAL_W-1:0]   pv;
    logic [PARTIAL_W-1:0]   pv_off;
    logic                   fin_bad;
    logic                   bad_seq;
    logic                   lead_emit;
    logic [15:0]            lead_unit;
    logic                   lead_sub;

    assign adv      = in_valid_reg && room;
    assign in_ready = !in_valid_reg || adv;
    assign load     = in_valid && in_ready;

    // Input register
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (load)
        begin
            in_valid_next = 1'b1;
        end
        else if (adv)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            in_byte_reg  <= in_byte;
            in_final_reg <= in_final;
        end
    end

    // Lead byte classification
    always_comb
    begin
        is_ascii    = !in_byte_reg[7];
        is_cont     = (in_byte_reg[7:6] == 2'b10);
        lead_ok     = 1'b1;
        lead_trails = '0;
        lead_bits   = '0;
        if (in_byte_reg[7:5] == 3'b110)
        begin
            lead_trails = 3'd1;
            lead_bits   = in_byte_reg[4:0];
        end
        else if (in_byte_reg[7:4] == 4'b1110)
        begin
            lead_trails = 3'd2;
            lead_bits   = {1'b0, in_byte_reg[3:0]};
        end
        else if (in_byte_reg[7:3] == 5'b11110)
        begin
            lead_trails = 3'd3;
            lead_bits   = {2'b0, in_byte_reg[2:0]};
        end
        else if (in_byte_reg[7:2] == 6'b111110)
        begin
            lead_trails = 3'd4;
            lead_bits   = {3'b0, in_byte_reg[1:0]};
        end
        else if (in_byte_reg[7:1] == 7'b1111110)
        begin
            lead_trails = 3'd5;
            lead_bits   = {4'b0, in_byte_reg[0]};
        end
        else
        begin
            lead_ok = 1'b0;
        end
    end

    // Completed value checks: overlong, 5/6-byte, surrogate, FFFE/FFFF, range
    assign pv     = {partial_reg[PARTIAL_W-7:0], in_byte_reg[5:0]};
    assign pv_off = pv - PARTIAL_W'(32'h10000);

    always_comb
    begin
        fin_bad = 1'b0;
        case (total_reg)
            3'd1:    fin_bad = (pv < PARTIAL_W'(32'h80));
            3'd2:    fin_bad = (pv < PARTIAL_W'(32'h800));
            3'd3:    fin_bad = (pv < PARTIAL_W'(32'h10000));
            default: fin_bad = 1'b1;
        endcase
        if ((pv >= PARTIAL_W'(32'hD800) && pv <= PARTIAL_W'(32'hDFFF))
            || pv == PARTIAL_W'(32'hFFFE) || pv == PARTIAL_W'(32'hFFFF)
            || pv > PARTIAL_W'(32'h10FFFF))
        begin
            fin_bad = 1'b1;
        end
    end

    // Next state and results
    always_comb
    begin
        partial_next = partial_reg;
        trails_next  = trails_reg;
        total_next   = total_reg;
        res          = '0;
        bad_seq      = 1'b0;
        lead_emit    = 1'b0;
        lead_unit    = '0;
        lead_sub     = 1'b0;
        if (adv)
        begin
            if (trails_reg != '0 && is_cont)
            begin
                if (trails_reg == 3'd1)
                begin
                    partial_next = '0;
                    trails_next  = '0;
                    total_next   = '0;
                    if (fin_bad)
                    begin
                        res.cnt   = 2'd1;
                        res.unit0 = REPLACEMENT;
                        res.sub0  = 1'b1;
                    end
                    else if (pv < PARTIAL_W'(32'h10000))
                    begin
                        res.cnt   = 2'd1;
                        res.unit0 = pv[15:0];
                    end
                    else
                    begin
                        res.cnt   = 2'd2;
                        res.unit0 = HIGH_SURR + {6'b0, pv_off[19:10]};
                        res.unit1 = LOW_SURR + {6'b0, pv_off[9:0]};
                    end
                end
                else if (in_final_reg)
                begin
                    partial_next = '0;
                    trails_next  = '0;
                    total_next   = '0;
                    res.cnt      = 2'd1;
                    res.unit0    = REPLACEMENT;
                    res.sub0     = 1'b1;
                end
                else
                begin
                    partial_next = pv;
                    trails_next  = trails_reg - 3'd1;
                end
            end
            else
            begin
                // broken sequence: replace it, then treat the byte as a lead
                bad_seq = (trails_reg != '0);
                if (bad_seq)
                begin
                    partial_next = '0;
                    trails_next  = '0;
                    total_next   = '0;
                end
                if (is_ascii)
                begin
                    lead_emit = 1'b1;
                    lead_unit = {8'b0, in_byte_reg};
                end
                else if (!lead_ok || in_final_reg)
                begin
                    lead_emit    = 1'b1;
                    lead_unit    = REPLACEMENT;
                    lead_sub     = 1'b1;
                    partial_next = '0;
                    trails_next  = '0;
                    total_next   = '0;
                end
                else
                begin
                    partial_next = {{(PARTIAL_W-5){1'b0}}, lead_bits};
                    trails_next  = lead_trails;
                    total_next   = lead_trails;
                end
                if (bad_seq)
                begin
                    res.unit0 = REPLACEMENT;
                    res.sub0  = 1'b1;
                    res.unit1 = lead_unit;
                    res.sub1  = lead_sub;
                    res.cnt   = lead_emit ? 2'd2 : 2'd1;
                end
                else
                begin
                    res.unit0 = lead_unit;
                    res.sub0  = lead_sub;
                    res.cnt   = lead_emit ? 2'd1 : 2'd0;
                end
            end
        end
    end

    // Sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            trails_reg  <= '0;
            total_reg   <= '0;
        end
        else
        begin
            partial_reg <= partial_next;
            trails_reg  <= trails_next;
            total_reg   <= total_next;
        end
    end

    // Checks
    a_trails_range: assert property (@(posedge clk) disable iff (!rst_n)
        trails_reg <= 3'd5)
        else $error("trail count out of range");

    a_trails_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        trails_reg != '0 |-> (total_reg >= trails_reg))
        else $error("trail count exceeds sequence length");

    a_pair_first: assert property (@(posedge clk) disable iff (!rst_n)
        res.cnt == 2'd2 |-> ((res.unit0 == REPLACEMENT && res.sub0)
                             || res.unit0[15:10] == 6'b110110))
        else $error("two-unit beat starts with neither FFFD nor high surrogate");

    a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |-> res.cnt == 2'd0)
        else $error("result produced without an advancing beat");

endmodule

// ===== sv/u8u16_outq.sv =====
module u8u16_outq
    import u8u16_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  u8u16_res_t  res,
    output logic        room,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] out_unit,
    output logic        out_sub,
    output logic        out_last
);

    logic [15:0]       unit_reg [QUEUE_DEPTH];
    logic              sub_reg  [QUEUE_DEPTH];
    logic              last_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic [QPTR_W-1:0] wr_ptr_p1;
    logic              pop;

    assign room      = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_unit  = unit_reg[rd_ptr_reg];
    assign out_sub   = sub_reg[rd_ptr_reg];
    assign out_last  = last_reg[rd_ptr_reg];
    assign wr_ptr_p1 = wr_ptr_reg + QPTR_W'(1);

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(res.cnt);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + QCNT_W'(res.cnt) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry writes; last flag marks the final unit of a beat
    always_ff @(posedge clk)
    begin
        if (res.cnt != 2'd0)
        begin
            unit_reg[wr_ptr_reg] <= res.unit0;
            sub_reg[wr_ptr_reg]  <= res.sub0;
            last_reg[wr_ptr_reg] <= (res.cnt == 2'd1);
        end
        if (res.cnt == 2'd2)
        begin
            unit_reg[wr_ptr_p1] <= res.unit1;
            sub_reg[wr_ptr_p1]  <= res.sub1;
            last_reg[wr_ptr_p1] <= 1'b1;
        end
    end

    // Checks
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue count beyond depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res.cnt != 2'd0 |-> room)
        else $error("push into result queue without room");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        QPTR_W'(count_reg) == QPTR_W'(wr_ptr_reg - rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

// ===== sv/utf8_to_utf16_transcoder.sv =====
// Channel  Dir  tdata                   tuser            tlast
// s_axis   in   [7:0] in_byte           -                final_byte
// m_axis   out  [15:0] code_unit        [0] substituted  run_end
//
// One byte is accepted per cycle while the result queue has room; its code units
// pass through the input register, then decode into the result queue.
// A byte that yields two units (surrogate pair or FFFD plus a new lead) holds
// the output for two beats; the four-entry result queue absorbs that.
// Input stalls only while the queue holds more than two units.
// Reset clears the sequence state and empties the queue.
module utf8_to_utf16_transcoder
    import u8u16_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] code_unit
    output logic        m_axis_tuser,   // [0] substituted
    output logic        m_axis_tlast
);

    u8u16_res_t res;
    logic       room;

    u8u16_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .in_final (s_axis_tlast),
        .room     (room),
        .res      (res)
    );

    u8u16_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_unit  (m_axis_tdata),
        .out_sub   (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule

// ===== tb/tb_utf8_to_utf16_transcoder.sv =====
`timescale 1ns / 1ps

module tb_utf8_to_utf16_transcoder
    import u8u16_pkg::*;
();

    // One UTF-16 code unit as seen on the master side
    typedef struct packed {
        logic [15:0] code_unit;
        logic        substituted;
        logic        run_end;
    } utf16_unit_t;

    // One pending input beat; drain marks a pause until all units are out
    typedef struct packed {
        logic [7:0] data;
        logic       fin;
        logic       drain;
    } utf8_beat_t;

    localparam int CALM_TAIL = 150;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] in_byte
    logic        s_axis_tlast = 1'b0;    // final_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;           // [15:0] code_unit
    logic        m_axis_tuser;           // [0] substituted
    logic        m_axis_tlast;           // run_end

    utf8_beat_t  pending_bytes[$];
    utf16_unit_t expected_units[$];
    utf16_unit_t step_units[$];

    // Decoder state mirror
    logic [30:0] cp_accum = '0;
    logic [2:0]  trails_pending = '0;
    logic [2:0]  trails_in_seq = '0;

    logic [7:0]  enc[0:5];
    int          n_pushed = 0;
    int          err_cnt = 0;
    int          send_gap = 0;
    int          ready_gap = 0;

    utf8_to_utf16_transcoder i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    task automatic go_idle();
        cp_accum       = '0;
        trails_pending = '0;
        trails_in_seq  = '0;
    endtask

    task automatic put_unit(input logic [15:0] cu, input logic sub);
        utf16_unit_t u;
        u.code_unit   = cu;
        u.substituted = sub;
        u.run_end     = 1'b0;
        step_units.push_back(u);
    endtask

    // Range checks on a completed code point, then BMP or surrogate pair
    task automatic close_value(input logic [31:0] val, input logic [2:0] total);
        logic [31:0] floor_val;
        logic [31:0] off;
        case (total)
            3'd1:    floor_val = 32'h0000_0080;
            3'd2:    floor_val = 32'h0000_0800;
            3'd3:    floor_val = 32'h0001_0000;
            default: floor_val = 32'hFFFF_FFFF;
        endcase
        off = val - 32'h0001_0000;
        if (val < floor_val)
            put_unit(REPLACEMENT, 1'b1);
        else if ((val >= 32'hD800 && val <= 32'hDFFF) || val == 32'hFFFE ||
                 val == 32'hFFFF || val > 32'h10_FFFF)
            put_unit(REPLACEMENT, 1'b1);
        else if (val < 32'h0001_0000)
            put_unit(val[15:0], 1'b0);
        else
        begin
            put_unit(HIGH_SURR + {6'd0, off[19:10]}, 1'b0);
            put_unit(LOW_SURR + {6'd0, off[9:0]}, 1'b0);
        end
    endtask

    // Lead byte decode from idle
    task automatic take_lead(input logic [7:0] b, input logic fin);
        logic [2:0]  trails;
        logic [30:0] bits;
        trails = 3'd0;
        bits   = '0;
        if (!b[7])
            put_unit({8'd0, b}, 1'b0);
        else
        begin
            if (b[7:5] == 3'b110)
            begin
                trails = 3'd1;
                bits   = 31'(b & 8'h1F);
            end
            else if (b[7:4] == 4'b1110)
            begin
                trails = 3'd2;
                bits   = 31'(b & 8'h0F);
            end
            else if (b[7:3] == 5'b11110)
            begin
                trails = 3'd3;
                bits   = 31'(b & 8'h07);
            end
            else if (b[7:2] == 6'b111110)
            begin
                trails = 3'd4;
                bits   = 31'(b & 8'h03);
            end
            else if (b[7:1] == 7'b1111110)
            begin
                trails = 3'd5;
                bits   = 31'(b & 8'h01);
            end

            // stray continuation or FE/FF
            if (trails == 3'd0)
                put_unit(REPLACEMENT, 1'b1);
            else if (fin)
            begin
                go_idle();
                put_unit(REPLACEMENT, 1'b1);
            end
            else
            begin
                cp_accum       = bits;
                trails_pending = trails;
                trails_in_seq  = trails;
            end
        end
    endtask

    // Expected code units for one accepted byte
    task automatic decode_utf8_byte(input logic [7:0] b, input logic fin);
        utf16_unit_t u;
        step_units.delete();
        if (trails_pending != 3'd0)
        begin
            if (b[7:6] == 2'b10)
            begin
                cp_accum       = {cp_accum[24:0], b[5:0]};
                trails_pending = trails_pending - 3'd1;
                if (trails_pending == 3'd0)
                begin
                    close_value({1'b0, cp_accum}, trails_in_seq);
                    go_idle();
                end
                else if (fin)
                begin
                    put_unit(REPLACEMENT, 1'b1);
                    go_idle();
                end
            end
            else
            begin
                // sequence broken by a non-trail byte, which starts anew
                put_unit(REPLACEMENT, 1'b1);
                go_idle();
                take_lead(b, fin);
            end
        end
        else
            take_lead(b, fin);

        for (int k = 0; k < step_units.size(); k++)
        begin
            u = step_units[k];
            u.run_end = (k == step_units.size() - 1);
            expected_units.push_back(u);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_in(input logic [7:0] b, input logic fin);
        utf8_beat_t it;
        it.data  = b;
        it.fin   = fin;
        it.drain = 1'b0;
        pending_bytes.push_back(it);
        n_pushed++;
    endtask

    task automatic push_drain();
        utf8_beat_t it;
        it.data  = 8'h00;
        it.fin   = 1'b0;
        it.drain = 1'b1;
        pending_bytes.push_back(it);
    endtask

    // UTF-8 form of cp in exactly len bytes (overlong when len is too big)
    task automatic encode(input logic [31:0] cp, input int len);
        logic [31:0] sh;
        if (len == 1)
            enc[0] = {1'b0, cp[6:0]};
        else
        begin
            for (int k = 1; k < len; k++)
            begin
                sh = cp >> (6 * (k - 1));
                enc[len - k] = {2'b10, sh[5:0]};
            end
            sh = cp >> (6 * (len - 1));
            case (len)
                2:       enc[0] = 8'hC0 | (sh[7:0] & 8'h1F);
                3:       enc[0] = 8'hE0 | (sh[7:0] & 8'h0F);
                4:       enc[0] = 8'hF0 | (sh[7:0] & 8'h07);
                5:       enc[0] = 8'hF8 | (sh[7:0] & 8'h03);
                default: enc[0] = 8'hFC | (sh[7:0] & 8'h01);
            endcase
        end
    endtask

    task automatic push_seq(input int keep, input logic fin);
        for (int k = 0; k < keep; k++)
            push_in(enc[k], fin && (k == keep - 1));
    endtask

    // ------------------------------------------------------------------
    // Driver: slave side
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || s_axis_tready))
        begin
            if (send_gap > 0)
            begin
                send_gap      <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_bytes.size() == 0)
                s_axis_tvalid <= 1'b0;
            else if (pending_bytes[0].drain)
            begin
                // hold valid low so the last beat is already predicted
                s_axis_tvalid <= 1'b0;
                if (!s_axis_tvalid && expected_units.size() == 0)
                    void'(pending_bytes.pop_front());
            end
            else
            begin
                s_axis_tdata  <= pending_bytes[0].data;
                s_axis_tlast  <= pending_bytes[0].fin;
                s_axis_tvalid <= 1'b1;
                void'(pending_bytes.pop_front());
                if (pending_bytes.size() > CALM_TAIL && $urandom_range(0, 4) == 0)
                    send_gap <= $urandom_range(1, 8);
            end
        end
    end

    // Receiver backpressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (ready_gap > 0)
            begin
                ready_gap     <= ready_gap - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (pending_bytes.size() > CALM_TAIL && $urandom_range(0, 5) == 0)
                    ready_gap <= $urandom_range(1, 8);
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on input beats, check output beats
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        utf16_unit_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                decode_utf8_byte(s_axis_tdata, s_axis_tlast);

            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_units.size() == 0)
                begin
                    $display("%0t: unexpected beat, expected none, actual %h sub %b last %b",
                             $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    err_cnt++;
                end
                else
                begin
                    want = expected_units.pop_front();
                    if (m_axis_tdata !== want.code_unit)
                    begin
                        $display("%0t: code_unit mismatch, expected %h, actual %h",
                                 $time, want.code_unit, m_axis_tdata);
                        err_cnt++;
                    end
                    if (m_axis_tuser !== want.substituted)
                    begin
                        $display("%0t: substituted mismatch, expected %b, actual %b",
                                 $time, want.substituted, m_axis_tuser);
                        err_cnt++;
                    end
                    if (m_axis_tlast !== want.run_end)
                    begin
                        $display("%0t: run_end mismatch, expected %b, actual %b",
                                 $time, want.run_end, m_axis_tlast);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int          rand_start;
        int          kind;
        int          len;
        int          keep;
        logic        fin;
        logic        mid_drain;
        logic [31:0] cp;

        mid_drain = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: ASCII extremes, stray and invalid bytes
        push_in(8'h00, 1'b0);
        push_in(8'h7F, 1'b1);
        push_in(8'h80, 1'b0);
        push_in(8'hFF, 1'b0);
        // two-byte char, then overlong two-byte NUL
        encode(32'hE9, 2);     push_seq(2, 1'b0);
        encode(32'h00, 2);     push_seq(2, 1'b0);
        // four-byte char as a surrogate pair
        encode(32'h1F600, 4);  push_seq(4, 1'b0);
        // encoded surrogate and FFFF
        encode(32'hD800, 3);   push_seq(3, 1'b0);
        encode(32'hFFFF, 3);   push_seq(3, 1'b0);
        // five-byte form
        encode(32'h200000, 5); push_seq(5, 1'b0);
        // open sequence broken by ASCII
        push_in(8'hC3, 1'b0);
        push_in(8'h41, 1'b0);
        // sequence cut short by the buffer end, then a lead on the last byte
        push_in(8'hE2, 1'b0);
        push_in(8'h82, 1'b1);
        push_in(8'hC3, 1'b1);
        push_drain();

        // Random: mostly well-formed characters, some malformed input
        rand_start = n_pushed;
        while (n_pushed - rand_start < 1400)
        begin
            kind = $urandom_range(0, 99);
            fin  = ($urandom_range(0, 9) == 0);
            if (kind < 68)
            begin
                len = $urandom_range(1, 4);
                case (len)
                    1:       cp = $urandom_range(32'h0, 32'h7F);
                    2:       cp = $urandom_range(32'h80, 32'h7FF);
                    3:       cp = $urandom_range(32'h800, 32'hFFFF);
                    default: cp = $urandom_range(32'h10000, 32'h10FFFF);
                endcase
                encode(cp, len);
                push_seq(len, fin);
            end
            else if (kind < 76)
                push_in(8'($urandom_range(0, 255)), fin);
            else if (kind < 82)
            begin
                // overlong
                len = $urandom_range(2, 4);
                case (len)
                    2:       cp = $urandom_range(32'h0, 32'h7F);
                    3:       cp = $urandom_range(32'h0, 32'h7FF);
                    default: cp = $urandom_range(32'h0, 32'hFFFF);
                endcase
                encode(cp, len);
                push_seq(len, fin);
            end
            else if (kind < 86)
            begin
                // five- and six-byte forms
                len = $urandom_range(5, 6);
                encode($urandom, len);
                push_seq(len, fin);
            end
            else if (kind < 90)
            begin
                // forbidden values
                case ($urandom_range(0, 2))
                    0:       begin cp = $urandom_range(32'hD800, 32'hDFFF); len = 3; end
                    1:       begin cp = 32'hFFFE + $urandom_range(0, 1); len = 3; end
                    default: begin cp = $urandom_range(32'h110000, 32'h1FFFFF); len = 4; end
                endcase
                encode(cp, len);
                push_seq(len, fin);
            end
            else if (kind < 95)
            begin
                // truncated sequence, buffer end or next lead
                len = $urandom_range(2, 4);
                encode($urandom_range(32'h80, 32'h10FFFF), len);
                keep = $urandom_range(1, len - 1);
                push_seq(keep, 1'($urandom_range(0, 1)));
            end
            else
            begin
                // one trail byte replaced by noise
                len = $urandom_range(2, 4);
                encode($urandom_range(32'h80, 32'h10FFFF), len);
                enc[$urandom_range(1, len - 1)] = 8'($urandom_range(0, 255));
                push_seq(len, fin);
            end

            if (!mid_drain && n_pushed - rand_start >= 700)
            begin
                push_drain();
                mid_drain = 1'b1;
            end
        end

        // Drain and finish
        while (pending_bytes.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_units.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (err_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/u8u16_pkg.sv
sv/u8u16_decode.sv
sv/u8u16_outq.sv
sv/utf8_to_utf16_transcoder.sv
tb/tb_utf8_to_utf16_transcoder.sv
